### hw/rtl/bpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bit-plane popcount dot product block.
// No dependencies; every module of the block imports this package.
package bpd_pkg;

    // Sizing limits
    localparam int MAX_DIM    = 4096;
    localparam int MAX_PLANES = 8;

    // Fixed field widths
    localparam int WordW = 64;
    localparam int DimW  = 13;
    localparam int PlnW  = 4;
    localparam int DotW  = 20;

    // Derived widths
    localparam int MaxBytes  = (MAX_DIM + 7) / 8;
    localparam int MaxWords  = (MaxBytes + 7) / 8;
    localparam int WordIdxW  = (MaxWords > 1) ? $clog2(MaxWords) : 1;
    localparam int WordCntW  = $clog2(MaxWords + 1);
    localparam int PlaneIdxW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CountW    = $clog2(MAX_DIM + 1);
    localparam int PopW      = $clog2(WordW + 1);
    localparam int BytesPerW = WordW / 8;

    // Configuration port
    localparam int CfgIdxW = 1;
    localparam int CfgDatW = DimW;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DIM_BITS   = 1'b0,
        REG_NUM_PLANES = 1'b1
    } t_cfg_reg;

    // Classified word passed from front to back
    typedef struct packed {
        logic [WordW-1:0]     bits;
        logic                 last_word;
        logic                 last_plane;
        logic [PlaneIdxW-1:0] plane_idx;
    } t_work;

    // Mid queue depth
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Output queue depth
    localparam int ODepth = 2;
    localparam int OPtrW  = $clog2(ODepth);
    localparam int OCntW  = $clog2(ODepth + 1);

endpackage

### hw/rtl/bpd_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, word/plane position tracking, byte mask.
// Depends on bpd_pkg.
module bpd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [bpd_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [bpd_pkg::CfgDatW-1:0]       i_cfg_data,
    input  logic                              i_accept,
    input  logic [bpd_pkg::WordW-1:0]         i_q_word,
    input  logic [bpd_pkg::WordW-1:0]         i_x_word,
    output bpd_pkg::t_work                    o_work
);
    import bpd_pkg::*;

    logic [DimW-1:0]      r_dim_bits;
    logic [PlnW-1:0]      r_num_planes;
    logic [WordIdxW-1:0]  r_word_idx, n_word_idx;
    logic [PlaneIdxW-1:0] r_plane_idx, n_plane_idx;

    logic [DimW-1:0]      dim_sat;
    logic [PlnW-1:0]      pln_sat;
    logic [DimW:0]        bytes_cnt;
    logic [DimW:0]        words_cnt;
    logic [2:0]           rem_bytes;
    logic                 last_word;
    logic                 last_plane;
    logic [WordW-1:0]     mask;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_bits   <= DimW'(128);
            r_num_planes <= PlnW'(4);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_DIM_BITS:   r_dim_bits   <= i_cfg_data;
                REG_NUM_PLANES: r_num_planes <= i_cfg_data[PlnW-1:0];
                default: ;
            endcase
        end
    end

    // Saturate registers and derive plane geometry
    always_comb begin
        if (r_dim_bits == '0) begin
            dim_sat = DimW'(1);
        end else if (32'(r_dim_bits) > MAX_DIM) begin
            dim_sat = DimW'(MAX_DIM);
        end else begin
            dim_sat = r_dim_bits;
        end
        if (r_num_planes == '0) begin
            pln_sat = PlnW'(1);
        end else if (32'(r_num_planes) > MAX_PLANES) begin
            pln_sat = PlnW'(MAX_PLANES);
        end else begin
            pln_sat = r_num_planes;
        end
        bytes_cnt = ({1'b0, dim_sat} + (DimW+1)'(7)) >> 3;
        words_cnt = (bytes_cnt + (DimW+1)'(7)) >> 3;
        rem_bytes = bytes_cnt[2:0];
    end

    // Classify the current word
    always_comb begin
        last_word  = ((DimW+1)'(r_word_idx) + (DimW+1)'(1)) >= words_cnt;
        last_plane = (5'(r_plane_idx) + 5'd1) >= 5'(pln_sat);
        for (int b = 0; b < BytesPerW; b++) begin
            mask[b*8 +: 8] = (!last_word || rem_bytes == 3'd0 || b < 32'(rem_bytes))
                             ? 8'hFF : 8'h00;
        end
        o_work.bits       = i_q_word & i_x_word & mask;
        o_work.last_word  = last_word;
        o_work.last_plane = last_plane;
        o_work.plane_idx  = r_plane_idx;
    end

    // Advance position counters
    always_comb begin
        n_word_idx  = r_word_idx;
        n_plane_idx = r_plane_idx;
        if (i_accept) begin
            if (!last_word) begin
                n_word_idx = r_word_idx + WordIdxW'(1);
            end else begin
                n_word_idx  = '0;
                n_plane_idx = last_plane ? '0 : r_plane_idx + PlaneIdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_idx  <= '0;
            r_plane_idx <= '0;
        end else begin
            r_word_idx  <= n_word_idx;
            r_plane_idx <= n_plane_idx;
        end
    end

endmodule

### hw/rtl/bpd_queue.sv
`timescale 1ns / 1ps
// Short queue of classified words between the front and back ends.
// Depends on bpd_pkg.
module bpd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  bpd_pkg::t_work  i_data,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_empty,
    output bpd_pkg::t_work  o_data
);
    import bpd_pkg::*;

    t_work             r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCntW-1:0]  r_count;

    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store incoming word
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + QPtrW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            end
            r_count <= r_count + QCntW'(i_wr) - QCntW'(i_rd);
        end
    end

endmodule

### hw/rtl/bpd_back.sv
`timescale 1ns / 1ps
// Back end: popcount, per-plane accumulate, weighted total and result queue.
// Depends on bpd_pkg.
module bpd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_work_valid,
    input  bpd_pkg::t_work              i_work,
    output logic                        o_work_take,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [bpd_pkg::DotW-1:0]    o_dot_value
);
    import bpd_pkg::*;

    logic [CountW-1:0] r_plane_count, n_plane_count;
    logic [DotW-1:0]   r_dot_total, n_dot_total;
    logic [DotW-1:0]   r_out_mem [ODepth];
    logic [OPtrW-1:0]  r_out_wr, r_out_rd;
    logic [OCntW-1:0]  r_out_cnt;

    logic [3:0]        byte_cnt [BytesPerW];
    logic [4:0]        pair_cnt [4];
    logic [5:0]        quad_cnt [2];
    logic [PopW-1:0]   pop_cnt;
    logic [CountW-1:0] plane_sum;
    logic [DotW-1:0]   total_sum;
    logic              out_full;
    logic              out_push;
    logic              out_pop;

    assign out_full    = (r_out_cnt == OCntW'(ODepth));
    assign o_work_take = i_work_valid && !out_full;
    assign o_empty     = (r_out_cnt == '0);
    assign o_dot_value = r_out_mem[r_out_rd];
    assign out_pop     = i_pop && !o_empty;

    // Count set bits per byte, then add the byte counts as a tree
    always_comb begin
        for (int b = 0; b < BytesPerW; b++) begin
            byte_cnt[b] = '0;
            for (int i = 0; i < 8; i++) begin
                byte_cnt[b] = byte_cnt[b] + 4'(i_work.bits[b*8 + i]);
            end
        end
        for (int h = 0; h < 4; h++) begin
            pair_cnt[h] = 5'(byte_cnt[2*h]) + 5'(byte_cnt[2*h + 1]);
        end
        for (int h = 0; h < 2; h++) begin
            quad_cnt[h] = 6'(pair_cnt[2*h]) + 6'(pair_cnt[2*h + 1]);
        end
        pop_cnt = PopW'(quad_cnt[0]) + PopW'(quad_cnt[1]);
    end

    // Accumulate plane count and weighted total
    always_comb begin
        plane_sum = r_plane_count + CountW'(pop_cnt);
        total_sum = r_dot_total + (DotW'(plane_sum) << i_work.plane_idx);
    end

    // Update plane count and total
    always_comb begin
        n_plane_count = r_plane_count;
        n_dot_total   = r_dot_total;
        out_push      = 1'b0;
        if (o_work_take) begin
            if (!i_work.last_word) begin
                n_plane_count = plane_sum;
            end else begin
                n_plane_count = '0;
                if (i_work.last_plane) begin
                    n_dot_total = '0;
                    out_push    = 1'b1;
                end else begin
                    n_dot_total = total_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_count <= '0;
            r_dot_total   <= '0;
        end else begin
            r_plane_count <= n_plane_count;
            r_dot_total   <= n_dot_total;
        end
    end

    // Hold finished totals until popped
    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out_mem[r_out_wr] <= total_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr  <= '0;
            r_out_rd  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (out_push) begin
                r_out_wr <= r_out_wr + OPtrW'(1);
            end
            if (out_pop) begin
                r_out_rd <= r_out_rd + OPtrW'(1);
            end
            r_out_cnt <= r_out_cnt + OCntW'(out_push) - OCntW'(out_pop);
        end
    end

endmodule

### hw/rtl/bitplane_popcount_dot.sv
`timescale 1ns / 1ps
// Top level of the bit-plane popcount dot product block.
// Depends on bpd_pkg, bpd_front, bpd_queue and bpd_back.

// The block takes one word (a 64-bit query chunk and its 64-bit code chunk)
// per clock while not full, plane by plane and word by word within a plane,
// and returns one 20-bit weighted popcount total after the last word of the
// last plane. Sustained rate is one word per cycle while the result queue
// has room: the front end masks and tags a word as it is pushed, and the back
// end does one 64-bit popcount and accumulate per cycle. A total is visible
// once the back end takes its last word. A four-word queue between front and
// back and a two-entry result queue absorb stalls on the result side. Write
// configuration only while no words are in flight; the port is always ready.
module bitplane_popcount_dot (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bpd_pkg::WordW-1:0]     i_q_word,
    input  logic [bpd_pkg::WordW-1:0]     i_x_word,
    output logic                          empty,
    input  logic                          pop,
    output logic [bpd_pkg::DotW-1:0]      o_dot_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [bpd_pkg::CfgDatW-1:0]   i_cfg_data
);
    import bpd_pkg::*;

    t_work front_work;
    t_work back_work;
    logic  accept;
    logic  q_empty;
    logic  q_take;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    bpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_q_word    (i_q_word),
        .i_x_word    (i_x_word),
        .o_work      (front_work)
    );

    bpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_data  (front_work),
        .o_full  (full),
        .i_rd    (q_take),
        .o_empty (q_empty),
        .o_data  (back_work)
    );

    bpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (!q_empty),
        .i_work       (back_work),
        .o_work_take  (q_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_dot_value  (o_dot_value)
    );

endmodule

### hw/rtl/bpd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for bitplane_popcount_dot, attached by bind.
// Depends on bpd_pkg.
module bpd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [bpd_pkg::DotW-1:0]      o_dot_value,
    input  logic                          o_cfg_ready
);
    import bpd_pkg::*;

    // Queues come out of reset with nothing held
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not clear after reset");

    // A waiting total holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_dot_value))
        else $error("waiting total changed before pop");

    // A total never exceeds the largest weighted sum
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_dot_value <= DotW'(1044480))
        else $error("total out of range");

    // Configuration port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind bitplane_popcount_dot bpd_checker u_bpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_dot_value (o_dot_value),
    .o_cfg_ready (o_cfg_ready)
);
